// ===== rtl/tpm_pkg.sv =====
// Package for the tree path-max block: field widths, codes, table entry
// and result types, shared helper functions.
// No dependencies.
package tpm_pkg;

    localparam int KIND_W     = 2;
    localparam int NODE_W     = 10;
    localparam int PARENT_W   = 11;
    localparam int WEIGHT_W   = 32;
    localparam int DEPTH_W    = 10;
    localparam int ANC_W      = 11;
    localparam int STATUS_W   = 2;
    localparam int CFG_W      = 11;

    localparam int DEF_MAX_NODES = 1024;
    localparam int DEF_LEVELS    = 11;

    localparam logic [CFG_W-1:0] NODE_COUNT_RST = 11'd1024;
    localparam logic [ANC_W-1:0] NO_NODE        = 11'h7FF;

    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BUILD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DEEPER = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BUILT  = 2'd2;

    typedef struct packed {
        logic [ANC_W-1:0]    anc;
        logic [WEIGHT_W-1:0] weight;
    } t_jump;

    typedef struct packed {
        logic [WEIGHT_W-1:0] max_weight;
        logic [STATUS_W-1:0] status;
    } t_result;

    function automatic logic [WEIGHT_W-1:0] f_wmax(input logic [WEIGHT_W-1:0] a,
                                                    input logic [WEIGHT_W-1:0] b);
        f_wmax = (a > b) ? a : b;
    endfunction

endpackage

// ===== rtl/tpm_ifs.sv =====
// Valid/ready channel interfaces: input items, result items, config writes.
// Depends on tpm_pkg.
interface tpm_in_if
    import tpm_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [KIND_W-1:0]          kind;
    logic [NODE_W-1:0]          node;
    logic signed [PARENT_W-1:0] parent_node;
    logic [WEIGHT_W-1:0]        edge_weight;
    logic [DEPTH_W-1:0]         node_depth;
    logic [NODE_W-1:0]          ancestor;

    modport source (output valid, kind, node, parent_node, edge_weight, node_depth,
                    ancestor, input ready);
    modport sink   (input valid, kind, node, parent_node, edge_weight, node_depth,
                    ancestor, output ready);
endinterface

interface tpm_out_if
    import tpm_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [WEIGHT_W-1:0] max_weight;
    logic [STATUS_W-1:0] status;

    modport source (output valid, max_weight, status, input ready);
    modport sink   (input valid, max_weight, status, output ready);
endinterface

interface tpm_cfg_if
    import tpm_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] node_count;

    modport source (output valid, node_count, input ready);
    modport sink   (input valid, node_count, output ready);
endinterface

// ===== rtl/tpm_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module tpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/tpm_seq.sv =====
// Sequencer: node load, level-by-level jump table build, and the
// depth-difference climb of a query through one shared compare unit.
// Depends on tpm_pkg and tpm_in_if.
module tpm_seq
    import tpm_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES,
    parameter int LEVELS    = DEF_LEVELS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    tpm_in_if.sink                                 i_in,
    input  logic [CFG_W-1:0]                       i_node_count,
    input  logic                                   i_out_free,
    output logic                                   o_res_valid,
    output t_result                                o_res,
    output logic                                   o_jump_we,
    output logic [$clog2(MAX_NODES*LEVELS)-1:0]    o_jump_waddr,
    output t_jump                                  o_jump_wdata,
    output logic                                   o_jump_re,
    output logic [$clog2(MAX_NODES*LEVELS)-1:0]    o_jump_raddr,
    input  t_jump                                  i_jump_rdata,
    output logic                                   o_depth_we,
    output logic [$clog2(MAX_NODES)-1:0]           o_depth_waddr,
    output logic [DEPTH_W-1:0]                     o_depth_wdata,
    output logic                                   o_depth_re,
    output logic [$clog2(MAX_NODES)-1:0]           o_depth_raddr,
    input  logic [DEPTH_W-1:0]                     i_depth_rdata
);
    localparam int AW    = $clog2(MAX_NODES*LEVELS);
    localparam int NW    = $clog2(MAX_NODES);
    localparam int VW    = (NW > NODE_W) ? NW : NODE_W;
    localparam int LW    = $clog2(LEVELS);
    localparam int CNT_W = $clog2(MAX_NODES+1);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_Q_RED  = 10'b0000000010,
        S_Q_DV   = 10'b0000000100,
        S_Q_DA   = 10'b0000001000,
        S_Q_SCAN = 10'b0000010000,
        S_Q_ACC  = 10'b0000100000,
        S_B_RD   = 10'b0001000000,
        S_B_CHK  = 10'b0010000000,
        S_B_WR   = 10'b0100000000,
        S_DONE   = 10'b1000000000
    } t_state;

    t_state              r_state, n_state;
    logic [VW-1:0]       r_v, n_v;
    logic [NODE_W-1:0]   r_a, n_a;
    logic [LW-1:0]       r_lev, n_lev;
    logic [LEVELS-1:0]   r_bits, n_bits;
    logic [WEIGHT_W-1:0] r_acc, n_acc;
    logic [DEPTH_W-1:0]  r_dv, n_dv;
    logic [CNT_W-1:0]    r_n, n_n;
    t_result             r_res, n_res;

    logic                accept;
    logic [CNT_W-1:0]    cnt_sat;
    logic                par_none;
    logic                ent_none;
    logic                last_v;
    logic                last_lev;
    logic [WEIGHT_W-1:0] acc_max;

    function automatic logic [AW-1:0] f_addr(input logic [VW-1:0] idx,
                                             input logic [LW-1:0] lev);
        f_addr = AW'(idx) * AW'(LEVELS) + AW'(lev);
    endfunction

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;

    assign cnt_sat  = (32'(i_node_count) > MAX_NODES) ? CNT_W'(MAX_NODES)
                                                      : CNT_W'(i_node_count);
    assign par_none = i_in.parent_node[PARENT_W-1]
                   || (32'(unsigned'(i_in.parent_node)) >= MAX_NODES);
    assign ent_none = (i_jump_rdata.anc == NO_NODE)
                   || (32'(i_jump_rdata.anc) >= MAX_NODES);
    assign last_v   = (32'(r_v) + 32'd1) == 32'(r_n);
    assign last_lev = (32'(r_lev) + 32'd1) == LEVELS;
    assign acc_max  = f_wmax(r_acc, i_jump_rdata.weight);

    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

    always_comb begin
        n_state = r_state;
        n_v     = r_v;
        n_a     = r_a;
        n_lev   = r_lev;
        n_bits  = r_bits;
        n_acc   = r_acc;
        n_dv    = r_dv;
        n_n     = r_n;
        n_res   = r_res;

        o_jump_we     = 1'b0;
        o_jump_waddr  = '0;
        o_jump_wdata  = '0;
        o_jump_re     = 1'b0;
        o_jump_raddr  = '0;
        o_depth_we    = 1'b0;
        o_depth_waddr = '0;
        o_depth_wdata = '0;
        o_depth_re    = 1'b0;
        o_depth_raddr = '0;

        case (r_state)
            S_IDLE: begin
                o_jump_waddr        = f_addr(VW'(i_in.node), '0);
                o_jump_wdata.anc    = par_none ? NO_NODE : ANC_W'(unsigned'(i_in.parent_node));
                o_jump_wdata.weight = i_in.edge_weight;
                o_depth_waddr       = NW'(i_in.node);
                o_depth_wdata       = i_in.node_depth;
                if (accept) begin
                    case (i_in.kind)
                        KIND_LOAD: begin
                            o_jump_we  = (32'(i_in.node) < MAX_NODES);
                            o_depth_we = (32'(i_in.node) < MAX_NODES);
                        end
                        KIND_BUILD: begin
                            n_v   = '0;
                            n_lev = LW'(1);
                            n_n   = cnt_sat;
                            if (cnt_sat == '0) begin
                                n_res   = '{max_weight: '0, status: ST_BUILT};
                                n_state = S_DONE;
                            end else begin
                                n_state = S_B_RD;
                            end
                        end
                        KIND_QUERY: begin
                            n_v     = VW'(i_in.node);
                            n_a     = i_in.ancestor;
                            n_state = S_Q_RED;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_Q_RED: begin
                if (32'(r_v) >= MAX_NODES) begin
                    n_v = r_v - VW'(MAX_NODES);
                end else if (32'(r_a) >= MAX_NODES) begin
                    n_a = r_a - NODE_W'(MAX_NODES);
                end else if (32'(r_v) == 32'(r_a)) begin
                    n_res   = '{max_weight: '0, status: ST_OK};
                    n_state = S_DONE;
                end else begin
                    o_depth_re    = 1'b1;
                    o_depth_raddr = NW'(r_v);
                    n_state       = S_Q_DV;
                end
            end
            S_Q_DV: begin
                n_dv          = i_depth_rdata;
                o_depth_re    = 1'b1;
                o_depth_raddr = NW'(r_a);
                n_state       = S_Q_DA;
            end
            S_Q_DA: begin
                if (i_depth_rdata > r_dv) begin
                    n_res   = '{max_weight: '0, status: ST_DEEPER};
                    n_state = S_DONE;
                end else begin
                    n_bits  = LEVELS'(DEPTH_W'(r_dv - i_depth_rdata));
                    n_lev   = LW'(LEVELS - 1);
                    n_acc   = '0;
                    n_state = S_Q_SCAN;
                end
            end
            S_Q_SCAN: begin
                if (r_bits[LEVELS-1]) begin
                    o_jump_re    = 1'b1;
                    o_jump_raddr = f_addr(r_v, r_lev);
                    n_state      = S_Q_ACC;
                end else if (r_lev == '0) begin
                    n_res   = '{max_weight: r_acc, status: ST_OK};
                    n_state = S_DONE;
                end else begin
                    n_lev  = r_lev - LW'(1);
                    n_bits = {r_bits[LEVELS-2:0], 1'b0};
                end
            end
            S_Q_ACC: begin
                n_acc = acc_max;
                if (ent_none || r_lev == '0) begin
                    n_res   = '{max_weight: acc_max, status: ST_OK};
                    n_state = S_DONE;
                end else begin
                    n_v     = VW'(i_jump_rdata.anc);
                    n_lev   = r_lev - LW'(1);
                    n_bits  = {r_bits[LEVELS-2:0], 1'b0};
                    n_state = S_Q_SCAN;
                end
            end
            S_B_RD: begin
                o_jump_re    = 1'b1;
                o_jump_raddr = f_addr(r_v, r_lev - LW'(1));
                n_state      = S_B_CHK;
            end
            S_B_CHK: begin
                n_acc = i_jump_rdata.weight;
                if (ent_none) begin
                    o_jump_we           = 1'b1;
                    o_jump_waddr        = f_addr(r_v, r_lev);
                    o_jump_wdata.anc    = NO_NODE;
                    o_jump_wdata.weight = i_jump_rdata.weight;
                end else begin
                    o_jump_re    = 1'b1;
                    o_jump_raddr = f_addr(VW'(i_jump_rdata.anc), r_lev - LW'(1));
                    n_state      = S_B_WR;
                end
            end
            S_B_WR: begin
                o_jump_we           = 1'b1;
                o_jump_waddr        = f_addr(r_v, r_lev);
                o_jump_wdata.anc    = i_jump_rdata.anc;
                o_jump_wdata.weight = acc_max;
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // advance the build walk after each table write
        if ((r_state == S_B_WR) || ((r_state == S_B_CHK) && ent_none)) begin
            if (!last_v) begin
                n_v     = r_v + VW'(1);
                n_state = S_B_RD;
            end else if (!last_lev) begin
                n_v     = '0;
                n_lev   = r_lev + LW'(1);
                n_state = S_B_RD;
            end else begin
                n_res   = '{max_weight: '0, status: ST_BUILT};
                n_state = S_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_v    <= n_v;
        r_a    <= n_a;
        r_lev  <= n_lev;
        r_bits <= n_bits;
        r_acc  <= n_acc;
        r_dv   <= n_dv;
        r_n    <= n_n;
        r_res  <= n_res;
    end
endmodule

// ===== rtl/tree_path_max_binary_lifting.sv =====
// Tree path-max by binary lifting. Load: back to ready next cycle. One item at a time.
// Query: two depth reads, then at most one jump-table read per set bit of the depth
// difference; the result then goes to the output register.
// Build: per level and node, read the entry one level down, then read its ancestor's entry
// if it has one, then write the new entry; the jump table has a single read port.
// Reset: sequencer idle, output empty, node_count = 1024; tables are not cleared.
module tree_path_max_binary_lifting
    import tpm_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES,
    parameter int LEVELS    = DEF_LEVELS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tpm_in_if.sink     i_in,
    tpm_cfg_if.sink    i_cfg,
    tpm_out_if.source  o_out
);
    localparam int AW = $clog2(MAX_NODES*LEVELS);
    localparam int NW = $clog2(MAX_NODES);

    logic [CFG_W-1:0]   r_node_count;
    logic               r_o_valid;
    t_result            r_o_res;

    logic               out_free;
    logic               res_valid;
    t_result            res;
    logic               jump_we;
    logic [AW-1:0]      jump_waddr;
    t_jump              jump_wdata;
    logic               jump_re;
    logic [AW-1:0]      jump_raddr;
    t_jump              jump_rdata;
    logic               depth_we;
    logic [NW-1:0]      depth_waddr;
    logic [DEPTH_W-1:0] depth_wdata;
    logic               depth_re;
    logic [NW-1:0]      depth_raddr;
    logic [DEPTH_W-1:0] depth_rdata;

    assign i_cfg.ready = 1'b1;
    assign out_free    = !r_o_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RST;
            r_o_valid    <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_node_count <= i_cfg.node_count;
            end
            if (res_valid && out_free) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
        if (res_valid && out_free) begin
            r_o_res <= res;
        end
    end

    assign o_out.valid      = r_o_valid;
    assign o_out.max_weight = r_o_res.max_weight;
    assign o_out.status     = r_o_res.status;

    tpm_seq #(
        .MAX_NODES (MAX_NODES),
        .LEVELS    (LEVELS)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .i_node_count  (r_node_count),
        .i_out_free    (out_free),
        .o_res_valid   (res_valid),
        .o_res         (res),
        .o_jump_we     (jump_we),
        .o_jump_waddr  (jump_waddr),
        .o_jump_wdata  (jump_wdata),
        .o_jump_re     (jump_re),
        .o_jump_raddr  (jump_raddr),
        .i_jump_rdata  (jump_rdata),
        .o_depth_we    (depth_we),
        .o_depth_waddr (depth_waddr),
        .o_depth_wdata (depth_wdata),
        .o_depth_re    (depth_re),
        .o_depth_raddr (depth_raddr),
        .i_depth_rdata (depth_rdata)
    );

    tpm_ram #(
        .WIDTH ($bits(t_jump)),
        .DEPTH (MAX_NODES*LEVELS)
    ) u_jump_ram (
        .i_clk   (i_clk),
        .i_we    (jump_we),
        .i_waddr (jump_waddr),
        .i_wdata (jump_wdata),
        .i_re    (jump_re),
        .i_raddr (jump_raddr),
        .o_rdata (jump_rdata)
    );

    tpm_ram #(
        .WIDTH (DEPTH_W),
        .DEPTH (MAX_NODES)
    ) u_depth_ram (
        .i_clk   (i_clk),
        .i_we    (depth_we),
        .i_waddr (depth_waddr),
        .i_wdata (depth_wdata),
        .i_re    (depth_re),
        .i_raddr (depth_raddr),
        .o_rdata (depth_rdata)
    );
endmodule

// ===== rtl/tpm_checker.sv =====
// Port-level checks for the tree path-max block, bound to the top level.
// Depends on tpm_pkg and tree_path_max_binary_lifting.
module tpm_checker
    import tpm_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic [KIND_W-1:0]   i_in_kind,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [WEIGHT_W-1:0] i_out_max_weight,
    input logic [STATUS_W-1:0] i_out_status
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_max_weight)
                                        && $stable(i_out_status))
        else $error("result beat changed while stalled");

    a_work_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_kind == KIND_BUILD || i_in_kind == KIND_QUERY)
        |=> !i_in_ready)
        else $error("ready while a build or query is in progress");

    a_load_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !(i_in_kind == KIND_BUILD || i_in_kind == KIND_QUERY)
        |=> i_in_ready)
        else $error("load beat did not return to ready");

    a_zero_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status == ST_DEEPER || i_out_status == ST_BUILT)
        |-> i_out_max_weight == '0)
        else $error("nonzero weight on error or build result");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_status == ST_OK || i_out_status == ST_DEEPER
                         || i_out_status == ST_BUILT))
        else $error("undefined status code on result beat");
endmodule

bind tree_path_max_binary_lifting tpm_checker u_tpm_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_in_kind        (i_in.kind),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_max_weight (o_out.max_weight),
    .i_out_status     (o_out.status)
);
